// ===== hw/rtl/tsbp_pkg.sv =====
package tsbp_pkg;

  localparam int BLOCK_COUNT = 256;
  localparam int ID_W        = 8;
  localparam int IDX_OUT_W   = 12;

  localparam logic signed [7:0] TY_VERSION    = -8'sd2;
  localparam logic signed [7:0] TY_TEMPO      = -8'sd3;
  localparam logic signed [7:0] TY_RESOLUTION = -8'sd4;
  localparam logic signed [7:0] TY_BLOCK_BEG  = -8'sd5;
  localparam logic signed [7:0] TY_BLOCK_END  = -8'sd6;
  localparam logic signed [7:0] TY_PLAY_BLOCK = -8'sd7;
  localparam logic signed [7:0] TY_SET_VOLUME = -8'sd8;
  localparam logic signed [7:0] TY_REPEAT     = -8'sd9;
  localparam logic signed [7:0] TY_SILENCE    = -8'sd1;

  localparam logic [7:0] VERSION_ONE     = 8'd1;
  localparam logic [7:0] TEMPO_DEFAULT   = 8'd30;
  localparam logic [7:0] RES_DEFAULT     = 8'd64;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_VERSION = 3'd1,
    ST_BAD_START   = 3'd2,
    ST_BAD_END     = 3'd3,
    ST_BAD_TYPE    = 3'd4,
    ST_TOO_LONG    = 3'd5
  } status_t;

  typedef struct packed {
    logic signed [7:0] event_type;
    logic signed [7:0] event_value;
    logic              last_event;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic signed [7:0]    tempo_now;
    logic signed [7:0]    resolution_now;
    logic                 main_found;
    logic [IDX_OUT_W-1:0] main_begin;
    logic                 block_closed;
    logic [ID_W-1:0]      closed_block_id;
    logic [IDX_OUT_W-1:0] closed_block_first;
    logic [IDX_OUT_W-1:0] closed_block_final;
    logic                 sequence_done;
  } out_item_t;

  // One block table entry.
  typedef struct packed {
    logic                 opened;
    logic                 ended;
    logic [IDX_OUT_W-1:0] first;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] id;
    entry_t          data;
    logic            clear;
  } wr_req_t;

endpackage

// ===== hw/rtl/tsbp_table.sv =====
module tsbp_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [tsbp_pkg::ID_W-1:0]         rd_id,
  input  tsbp_pkg::wr_req_t                 wr_req,
  output tsbp_pkg::entry_t                  entry
);

  tsbp_pkg::entry_t mem_r [tsbp_pkg::BLOCK_COUNT];
  tsbp_pkg::entry_t rd_q_r;
  tsbp_pkg::entry_t fwd_data_r;
  logic [tsbp_pkg::BLOCK_COUNT-1:0] vld_r;
  logic rd_vld_r;
  logic fwd_r;

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem_r[wr_req.id] <= wr_req.data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_id];
    end
  end

  // Valid bits make an entry read as cleared until it is written in this sequence.
  always_ff @(posedge clk) begin
    if (!rst_n || wr_req.clear) begin
      vld_r <= '0;
    end else if (wr_req.en) begin
      vld_r[wr_req.id] <= 1'b1;
    end
  end

  // A read issued at the same edge as a write to the same entry or a clear takes the new value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_id];
      fwd_r    <= wr_req.clear || (wr_req.en && (wr_req.id == rd_id));
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_req.clear ? '0 : wr_req.data;
    end
  end

  always_comb begin
    if (fwd_r) begin
      entry = fwd_data_r;
    end else if (rd_vld_r) begin
      entry = rd_q_r;
    end else begin
      entry = '0;
    end
  end

`ifndef SYNTHESIS
  a_fwd_same_id: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_req.en && !wr_req.clear && (wr_req.id == rd_id))
      |=> (entry == $past(wr_req.data)))
    else $error("table forwarding lost a write to the entry being read");

  a_clear_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_req.clear) |=> (entry == '0))
    else $error("entry read across a clear is not cleared");
`endif

endmodule

// ===== hw/rtl/tsbp_ctrl.sv =====
module tsbp_ctrl #(
  parameter int MAX_EVENTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  tsbp_pkg::in_item_t   item,
  input  tsbp_pkg::entry_t     entry,
  output tsbp_pkg::out_item_t  result,
  output tsbp_pkg::wr_req_t    wr_req
);

  localparam int IW = $clog2(MAX_EVENTS + 1);
  localparam logic [IW-1:0] IDX_MAX = IW'(MAX_EVENTS);
  localparam int OW = tsbp_pkg::IDX_OUT_W;

  logic [IW-1:0]      idx_r, idx_nxt;
  logic               in_blk_r, in_blk_nxt;
  logic               in_main_r, in_main_nxt;
  logic [OW-1:0]      main_idx_r, main_idx_nxt;
  logic [7:0]         tempo_r, tempo_nxt;
  logic [7:0]         res_r, res_nxt;
  tsbp_pkg::status_t  err_r, err_nxt;

  logic signed [7:0]              ty;
  logic [7:0]                     vbits;
  logic [tsbp_pkg::ID_W-1:0]      id;
  logic                           closed;
  logic [OW-1:0]                  c_first;
  logic [OW-1:0]                  c_final;
  logic                           is_play;

  always_comb begin
    ty      = item.event_type;
    vbits   = item.event_value;
    id      = vbits;
    is_play = (ty >= tsbp_pkg::TY_SILENCE) || (ty == tsbp_pkg::TY_PLAY_BLOCK) ||
              (ty == tsbp_pkg::TY_SET_VOLUME) || (ty == tsbp_pkg::TY_REPEAT);

    idx_nxt      = (idx_r < IDX_MAX) ? idx_r + IW'(1) : idx_r;
    in_blk_nxt   = in_blk_r;
    in_main_nxt  = in_main_r;
    main_idx_nxt = main_idx_r;
    tempo_nxt    = tempo_r;
    res_nxt      = res_r;
    err_nxt      = err_r;
    closed       = 1'b0;
    c_first      = '0;
    c_final      = '0;
    wr_req.en    = 1'b0;
    wr_req.id    = id;
    wr_req.data  = entry;
    wr_req.clear = 1'b0;

    if (err_r == tsbp_pkg::ST_OK) begin
      priority if (idx_r >= IDX_MAX) begin
        err_nxt = tsbp_pkg::ST_TOO_LONG;
      end else if (idx_r == '0) begin
        if (ty != tsbp_pkg::TY_VERSION || vbits != tsbp_pkg::VERSION_ONE) begin
          err_nxt = tsbp_pkg::ST_BAD_VERSION;
        end
      end else if (ty == tsbp_pkg::TY_TEMPO) begin
        tempo_nxt = vbits;
      end else if (ty == tsbp_pkg::TY_RESOLUTION) begin
        res_nxt = vbits;
      end else if (ty == tsbp_pkg::TY_BLOCK_BEG) begin
        if (entry.opened || in_blk_r || in_main_r) begin
          err_nxt = tsbp_pkg::ST_BAD_START;
        end else begin
          wr_req.en          = 1'b1;
          wr_req.data.opened = 1'b1;
          wr_req.data.first  = OW'(idx_r) + OW'(1);
          in_blk_nxt         = 1'b1;
        end
      end else if (ty == tsbp_pkg::TY_BLOCK_END) begin
        if (!entry.opened || entry.ended || !in_blk_r) begin
          err_nxt = tsbp_pkg::ST_BAD_END;
        end else begin
          wr_req.en         = 1'b1;
          wr_req.data.ended = 1'b1;
          in_blk_nxt        = 1'b0;
          closed            = 1'b1;
          c_first           = entry.first;
          c_final           = OW'(idx_r) - OW'(1);
        end
      end else if (is_play) begin
        if (!in_blk_r && !in_main_r) begin
          in_main_nxt  = 1'b1;
          main_idx_nxt = OW'(idx_r);
        end
      end else begin
        err_nxt = tsbp_pkg::ST_BAD_TYPE;
      end
    end

    result.status             = err_nxt;
    result.tempo_now          = tempo_nxt;
    result.resolution_now     = res_nxt;
    result.main_found         = in_main_nxt;
    result.main_begin         = main_idx_nxt;
    result.block_closed       = closed;
    result.closed_block_id    = closed ? id : '0;
    result.closed_block_first = c_first;
    result.closed_block_final = c_final;
    result.sequence_done      = item.last_event;

    wr_req.en    = wr_req.en && adv;
    wr_req.clear = adv && item.last_event;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && item.last_event)) begin
      idx_r      <= '0;
      in_blk_r   <= 1'b0;
      in_main_r  <= 1'b0;
      main_idx_r <= '0;
      tempo_r    <= tsbp_pkg::TEMPO_DEFAULT;
      res_r      <= tsbp_pkg::RES_DEFAULT;
      err_r      <= tsbp_pkg::ST_OK;
    end else if (adv) begin
      idx_r      <= idx_nxt;
      in_blk_r   <= in_blk_nxt;
      in_main_r  <= in_main_nxt;
      main_idx_r <= main_idx_nxt;
      tempo_r    <= tempo_nxt;
      res_r      <= res_nxt;
      err_r      <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (err_r != tsbp_pkg::ST_OK) && !item.last_event) |=> (err_r == $past(err_r)))
    else $error("sticky error code changed before the end of the sequence");
`endif

endmodule

// ===== hw/rtl/tone_sequence_block_parser.sv =====
// Tone sequence block parser.
// Input channel in_valid/in_stall/in_data carries one event request per
// cycle: a signed type, a signed value and a last-event flag. Every event
// produces exactly one result request on out_valid/out_stall/out_data with
// the sticky status, current tempo and resolution, the main sequence start
// and, for a valid block end, the closed block's id and inner index range.
// An accepted event is held in the update stage register, and its result
// is registered in the output register as the event leaves that stage.
// Throughput is one event per cycle while out_stall is low; the rate is set
// by the block table, a synchronous memory with one read and one write port,
// read at acceptance and written back as the event leaves the update stage,
// with forwarding covering back-to-back events on the same block id.
// When out_stall is high the result holds in the output register, the
// event in the update stage waits, and in_stall rises so one more event
// cannot enter until the result is taken.
// Synchronous reset (rst_n low) empties the pipeline and restores tempo 30,
// resolution 64, status ok and all block marks cleared; block marks are
// cleared at once through per-entry valid bits, so no clearing pass is
// needed. The same clear happens after an event with last_event set.
module tone_sequence_block_parser #(
  parameter int MAX_EVENTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tsbp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsbp_pkg::out_item_t  out_data
);

  logic                 s1_valid_r;
  tsbp_pkg::in_item_t   s1_item_r;
  logic                 out_valid_r;
  tsbp_pkg::out_item_t  out_data_r;

  logic                 s1_adv;
  logic                 in_acc;
  tsbp_pkg::entry_t     entry;
  tsbp_pkg::wr_req_t    wr_req;
  tsbp_pkg::out_item_t  result;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  tsbp_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc),
    .rd_id  (in_data.event_value),
    .wr_req (wr_req),
    .entry  (entry)
  );

  tsbp_ctrl #(
    .MAX_EVENTS (MAX_EVENTS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (s1_adv),
    .item   (s1_item_r),
    .entry  (entry),
    .result (result),
    .wr_req (wr_req)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_closed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.block_closed) |-> (out_data_r.status == tsbp_pkg::ST_OK))
    else $error("block closed reported together with an error status");

  a_main_begin_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.main_found) |-> (out_data_r.main_begin == '0))
    else $error("main start index set while main sequence not found");

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("event left the update stage without a result");
`endif

endmodule
